FILE: hdl/iaqd_pkg.sv
// Package for the impulse arrival quadrant detector.
// Widths, register codes, reset values, quadrant codes and the arrival record.
// No dependencies.
`timescale 1ns / 1ps

package iaqd_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 10;
   localparam int CSR_INDEX_WIDTH      = 3;
   localparam int NUM_CHANNELS         = 4;
   localparam int CHAN_WIDTH           = 2;
   localparam int COUNT_WIDTH          = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_HIGH        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_LOW         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_WINDOW_LOW  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_WINDOW_HIGH = 3'd3;

   localparam int PEAK_HIGH_RESET        = 700;
   localparam int PEAK_LOW_RESET         = 300;
   localparam int ZERO_WINDOW_LOW_RESET  = 510;
   localparam int ZERO_WINDOW_HIGH_RESET = 515;

   localparam logic [2:0] QUAD_ONE       = 3'd0;
   localparam logic [2:0] QUAD_FOUR      = 3'd3;
   localparam logic [2:0] QUAD_AMBIGUOUS = 3'd4;
   localparam logic [3:0] MASK_ALL       = 4'hF;

   typedef struct packed {
      logic                  emit;
      logic [CHAN_WIDTH-1:0] first;
      logic [CHAN_WIDTH-1:0] second;
   } arrival_type;

endpackage

FILE: hdl/iaqd_csr.sv
// Threshold and window registers of the quadrant detector.
// Depends on iaqd_pkg.
`timescale 1ns / 1ps

module iaqd_csr #(
   parameter int SAMPLE_WIDTH = iaqd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [iaqd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SAMPLE_WIDTH-1:0]              csr_write_data,
   output logic [SAMPLE_WIDTH-1:0]              peak_high,
   output logic [SAMPLE_WIDTH-1:0]              peak_low,
   output logic [SAMPLE_WIDTH-1:0]              zero_window_low,
   output logic [SAMPLE_WIDTH-1:0]              zero_window_high
);
   import iaqd_pkg::*;

   logic [SAMPLE_WIDTH-1:0] peak_high_ff, peak_low_ff, zwin_low_ff, zwin_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_high_ff <= SAMPLE_WIDTH'(PEAK_HIGH_RESET);
         peak_low_ff  <= SAMPLE_WIDTH'(PEAK_LOW_RESET);
         zwin_low_ff  <= SAMPLE_WIDTH'(ZERO_WINDOW_LOW_RESET);
         zwin_high_ff <= SAMPLE_WIDTH'(ZERO_WINDOW_HIGH_RESET);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PEAK_HIGH:        peak_high_ff <= csr_write_data;
            CSR_PEAK_LOW:         peak_low_ff  <= csr_write_data;
            CSR_ZERO_WINDOW_LOW:  zwin_low_ff  <= csr_write_data;
            CSR_ZERO_WINDOW_HIGH: zwin_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign peak_high        = peak_high_ff;
   assign peak_low         = peak_low_ff;
   assign zero_window_low  = zwin_low_ff;
   assign zero_window_high = zwin_high_ff;

endmodule

FILE: hdl/iaqd_track.sv
// Per-channel phase tracking and arrival ordering of the quadrant detector.
// Depends on iaqd_pkg.
`timescale 1ns / 1ps

module iaqd_track #(
   parameter int SAMPLE_WIDTH = iaqd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [SAMPLE_WIDTH-1:0] sample [iaqd_pkg::NUM_CHANNELS],
   input  logic [SAMPLE_WIDTH-1:0] peak_high,
   input  logic [SAMPLE_WIDTH-1:0] peak_low,
   input  logic [SAMPLE_WIDTH-1:0] zero_window_low,
   input  logic [SAMPLE_WIDTH-1:0] zero_window_high,
   output iaqd_pkg::arrival_type   arrival
);
   import iaqd_pkg::*;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_ARMED = 2'd1,
      PHASE_DONE  = 2'd2
   } phase_type;

   phase_type               phase_ff [NUM_CHANNELS];
   phase_type               phase_in [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [CHAN_WIDTH-1:0]   first_ff, first_in, second_ff, second_in;
   logic [NUM_CHANNELS-1:0] armed_now, finish;
   logic                    emit;

   always_comb begin
      logic [COUNT_WIDTH-1:0] pos;
      pos       = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         armed_now[c] = (phase_ff[c] == PHASE_ARMED) ||
                        ((phase_ff[c] == PHASE_IDLE) &&
                         ((sample[c] > peak_high) || (sample[c] < peak_low)));
         finish[c]    = armed_now[c] && (sample[c] >= zero_window_low) &&
                        (sample[c] <= zero_window_high);
         if (finish[c]) begin
            if (pos == COUNT_WIDTH'(0)) first_in = CHAN_WIDTH'(c);
            if (pos == COUNT_WIDTH'(1)) second_in = CHAN_WIDTH'(c);
            pos = pos + COUNT_WIDTH'(1);
         end
         if (finish[c]) begin
            phase_in[c] = PHASE_DONE;
         end else if (armed_now[c]) begin
            phase_in[c] = PHASE_ARMED;
         end else begin
            phase_in[c] = phase_ff[c];
         end
      end
      emit     = (pos >= COUNT_WIDTH'(NUM_CHANNELS));
      count_in = pos;
      if (emit) begin
         count_in = '0;
         for (int c = 0; c < NUM_CHANNELS; c++) phase_in[c] = PHASE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) phase_ff[c] <= PHASE_IDLE;
      end else if (fire) begin
         count_ff <= count_in;
         for (int c = 0; c < NUM_CHANNELS; c++) phase_ff[c] <= phase_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign arrival.emit   = fire && emit;
   assign arrival.first  = first_in;
   assign arrival.second = second_in;

endmodule

FILE: hdl/iaqd_decode.sv
// Maps the first two arrivals to a quadrant code and LED mask.
// Depends on iaqd_pkg.
`timescale 1ns / 1ps

module iaqd_decode (
   input  logic [iaqd_pkg::CHAN_WIDTH-1:0] first,
   input  logic [iaqd_pkg::CHAN_WIDTH-1:0] second,
   output logic [2:0]                      quadrant,
   output logic [3:0]                      led_mask
);
   import iaqd_pkg::*;

   logic [CHAN_WIDTH-1:0] lo, hi;

   always_comb begin
      lo = (first < second) ? first : second;
      hi = (first < second) ? second : first;
      if ({1'b0, hi} == {1'b0, lo} + 3'd1) begin
         quadrant = {1'b0, lo};
      end else if ((lo == 2'd0) && (hi == 2'd3)) begin
         quadrant = QUAD_FOUR;
      end else begin
         quadrant = QUAD_AMBIGUOUS;
      end
      if (quadrant == QUAD_AMBIGUOUS) begin
         led_mask = MASK_ALL;
      end else begin
         led_mask = 4'b0001 << quadrant[1:0];
      end
   end

endmodule

FILE: hdl/impulse_arrival_quadrant_detector_unit.sv
// Top level of the impulse arrival quadrant detector.
// Depends on iaqd_pkg, iaqd_csr, iaqd_track and iaqd_decode.
`timescale 1ns / 1ps

// Takes one four-channel sample set per transfer and reports a quadrant once all
// four channels have armed and crossed the zero window. A sample set is held in
// an input register; the phase update and quadrant decode then load the result
// register from it once the result side can advance. One sample set is taken
// every cycle while the result side is not stalled; the input stalls only while
// a result waits and the input register is full. Threshold writes take effect
// at the next clock edge and should be made while the block is idle.
module impulse_arrival_quadrant_detector_unit #(
   parameter int SAMPLE_WIDTH = iaqd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_WIDTH-1:0]              req_sample_ch1,
   input  logic [SAMPLE_WIDTH-1:0]              req_sample_ch2,
   input  logic [SAMPLE_WIDTH-1:0]              req_sample_ch3,
   input  logic [SAMPLE_WIDTH-1:0]              req_sample_ch4,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_quadrant,
   output logic [3:0]                           rsp_led_mask,
   output logic [iaqd_pkg::CHAN_WIDTH-1:0]      rsp_first_channel,
   output logic [iaqd_pkg::CHAN_WIDTH-1:0]      rsp_second_channel,
   input  logic                                 csr_write_enable,
   input  logic [iaqd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SAMPLE_WIDTH-1:0]              csr_write_data
);
   import iaqd_pkg::*;

   logic                    s1_valid_ff, s1_valid_in;
   logic [SAMPLE_WIDTH-1:0] s1_sample_ff [NUM_CHANNELS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_quadrant_ff;
   logic [3:0]              rsp_led_mask_ff;
   logic [CHAN_WIDTH-1:0]   rsp_first_ff, rsp_second_ff;
   logic [SAMPLE_WIDTH-1:0] peak_high, peak_low, zero_window_low, zero_window_high;
   logic                    advance, fire, req_take;
   arrival_type             arrival;
   logic [2:0]              quadrant;
   logic [3:0]              led_mask;

   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = s1_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign fire         = s1_valid_ff && advance;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? arrival.emit : rsp_valid_ff;

   iaqd_csr #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .peak_high        (peak_high),
      .peak_low         (peak_low),
      .zero_window_low  (zero_window_low),
      .zero_window_high (zero_window_high)
   );

   iaqd_track #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_track (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .sample           (s1_sample_ff),
      .peak_high        (peak_high),
      .peak_low         (peak_low),
      .zero_window_low  (zero_window_low),
      .zero_window_high (zero_window_high),
      .arrival          (arrival)
   );

   iaqd_decode u_decode (
      .first    (arrival.first),
      .second   (arrival.second),
      .quadrant (quadrant),
      .led_mask (led_mask)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff[0] <= req_sample_ch1;
         s1_sample_ff[1] <= req_sample_ch2;
         s1_sample_ff[2] <= req_sample_ch3;
         s1_sample_ff[3] <= req_sample_ch4;
      end
      if (advance && arrival.emit) begin
         rsp_quadrant_ff <= quadrant;
         rsp_led_mask_ff <= led_mask;
         rsp_first_ff    <= arrival.first;
         rsp_second_ff   <= arrival.second;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quadrant       = rsp_quadrant_ff;
   assign rsp_led_mask       = rsp_led_mask_ff;
   assign rsp_first_channel  = rsp_first_ff;
   assign rsp_second_channel = rsp_second_ff;

endmodule

FILE: hdl/iaqd_checker.sv
// Port-level checks for the quadrant detector, bound to the top level.
// Depends on iaqd_pkg and impulse_arrival_quadrant_detector_unit.
`timescale 1ns / 1ps

module iaqd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [2:0]                      rsp_quadrant,
   input logic [3:0]                      rsp_led_mask,
   input logic [iaqd_pkg::CHAN_WIDTH-1:0] rsp_first_channel,
   input logic [iaqd_pkg::CHAN_WIDTH-1:0] rsp_second_channel
);
   import iaqd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quadrant))
      else $error("result dropped or changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ambiguous_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_quadrant == QUAD_AMBIGUOUS) == (rsp_led_mask == MASK_ALL)))
      else $error("mask does not match ambiguous code");

   a_single_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_quadrant != QUAD_AMBIGUOUS) |->
         $onehot(rsp_led_mask) && (rsp_led_mask[rsp_quadrant[1:0]] == 1'b1))
      else $error("quadrant LED mask wrong");

   a_distinct_arrivals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_channel != rsp_second_channel)
      else $error("first and second arrival are the same channel");

endmodule

bind impulse_arrival_quadrant_detector_unit iaqd_checker u_iaqd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_quadrant       (rsp_quadrant),
   .rsp_led_mask       (rsp_led_mask),
   .rsp_first_channel  (rsp_first_channel),
   .rsp_second_channel (rsp_second_channel)
);

FILE: tb/testbench.sv
// Self-checking testbench for impulse_arrival_quadrant_detector_unit.
// Drives four-channel sample sets, predicts the quadrant reports and compares them.
// Depends on iaqd_pkg and the detector RTL.
`timescale 1ns / 1ps

module testbench;
   import iaqd_pkg::*;

   localparam int SW            = SAMPLE_WIDTH_DEFAULT;
   localparam int SAMPLE_MAX    = (1 << SW) - 1;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd6;

   typedef logic [3:0][SW-1:0] sample_set_type;
   typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_ARMED = 2'd1, PH_DONE = 2'd2} phase_type;
   typedef enum {DRAW_ARM, DRAW_ZERO, DRAW_QUIET, DRAW_ANY} draw_kind_type;

   typedef struct packed {
      logic [2:0]            quadrant;
      logic [3:0]            led_mask;
      logic [CHAN_WIDTH-1:0] first;
      logic [CHAN_WIDTH-1:0] second;
   } quadrant_report_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_quadrant;
   logic [3:0] rsp_led_mask;
   logic [CHAN_WIDTH-1:0] rsp_first_channel;
   logic [CHAN_WIDTH-1:0] rsp_second_channel;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_PEAK_HIGH;
   logic [SW-1:0] csr_write_data = '0;
   sample_set_type offered = '0;

   sample_set_type sample_sets[$];
   quadrant_report_type expected_reports[$];
   int items_queued = 0;
   int items_accepted = 0;
   int mismatches = 0;
   int cycles = 0;
   int send_gap = 0;
   int rsp_stall_left = 0;
   bit steady = 1'b0;
   bit squeeze = 1'b0;
   logic hold_off = 1'b0;

   logic [SW-1:0] thr_high = SW'(PEAK_HIGH_RESET);
   logic [SW-1:0] thr_low  = SW'(PEAK_LOW_RESET);
   logic [SW-1:0] win_low  = SW'(ZERO_WINDOW_LOW_RESET);
   logic [SW-1:0] win_high = SW'(ZERO_WINDOW_HIGH_RESET);
   phase_type chan_phase [4] = '{default: PH_IDLE};
   int arrivals = 0;
   logic [CHAN_WIDTH-1:0] first_arr = '0;
   logic [CHAN_WIDTH-1:0] second_arr = '0;

   impulse_arrival_quadrant_detector_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_ch1     (offered[0]),
      .req_sample_ch2     (offered[1]),
      .req_sample_ch3     (offered[2]),
      .req_sample_ch4     (offered[3]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quadrant       (rsp_quadrant),
      .rsp_led_mask       (rsp_led_mask),
      .rsp_first_channel  (rsp_first_channel),
      .rsp_second_channel (rsp_second_channel),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Advance the arrival tracking by one sample set; queue a report on the fourth arrival.
   function automatic void track_arrivals(sample_set_type s);
      quadrant_report_type rep;
      logic [CHAN_WIDTH-1:0] lo, hi;
      for (int c = 0; c < NUM_CHANNELS; c++)
         if (chan_phase[c] == PH_IDLE && (s[c] > thr_high || s[c] < thr_low))
            chan_phase[c] = PH_ARMED;
      for (int c = 0; c < NUM_CHANNELS; c++)
         if (chan_phase[c] == PH_ARMED && s[c] >= win_low && s[c] <= win_high) begin
            if (arrivals == 0) first_arr = CHAN_WIDTH'(c);
            else if (arrivals == 1) second_arr = CHAN_WIDTH'(c);
            arrivals++;
            chan_phase[c] = PH_DONE;
         end
      if (arrivals == NUM_CHANNELS) begin
         lo = (first_arr < second_arr) ? first_arr : second_arr;
         hi = (first_arr < second_arr) ? second_arr : first_arr;
         if (int'(hi) == int'(lo) + 1) rep.quadrant = QUAD_ONE + 3'(lo);
         else if (lo == 0 && int'(hi) == NUM_CHANNELS - 1) rep.quadrant = QUAD_FOUR;
         else rep.quadrant = QUAD_AMBIGUOUS;
         rep.led_mask = (rep.quadrant == QUAD_AMBIGUOUS) ? MASK_ALL : 4'b1 << rep.quadrant;
         rep.first = first_arr;
         rep.second = second_arr;
         expected_reports.push_back(rep);
         for (int c = 0; c < NUM_CHANNELS; c++) chan_phase[c] = PH_IDLE;
         arrivals = 0;
         first_arr = '0;
         second_arr = '0;
      end
   endfunction

   function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_report();
      quadrant_report_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: report with none expected: quadrant %0d mask %h first %0d second %0d",
                  $time, rsp_quadrant, rsp_led_mask, rsp_first_channel, rsp_second_channel);
         mismatches++;
         return;
      end
      want = expected_reports.pop_front();
      compare_field("quadrant", 4'(want.quadrant), 4'(rsp_quadrant));
      compare_field("led_mask", want.led_mask, rsp_led_mask);
      compare_field("first_channel", 4'(want.first), 4'(rsp_first_channel));
      compare_field("second_channel", 4'(want.second), 4'(rsp_second_channel));
   endfunction

   always @(posedge clock) begin : driver
      sample_set_type next_set;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            track_arrivals(offered);
            items_accepted++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (sample_sets.size() != 0) begin
            next_set = sample_sets.pop_front();
            offered <= next_set;
            req_valid <= 1'b1;
            send_gap <= (!steady && $urandom_range(0, 99) < 35) ? idle_length() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_report();
         if (rsp_stall_left != 0) begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!steady && $urandom_range(0, 99) < 25) begin
            rsp_stall_left <= idle_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= hold_off;
         end
      end
   end

   // Hold off the result side long enough for the block to back up into its input.
   initial begin
      wait (squeeze);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("impulse_arrival_quadrant_detector_unit: mismatch");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= SW'(value);
      case (idx)
         CSR_PEAK_HIGH:        thr_high = SW'(value);
         CSR_PEAK_LOW:         thr_low = SW'(value);
         CSR_ZERO_WINDOW_LOW:  win_low = SW'(value);
         CSR_ZERO_WINDOW_HIGH: win_high = SW'(value);
         default: ;
      endcase
   endtask

   task automatic set_thresholds(int high, int low, int wlo, int whi);
      csr_write(CSR_PEAK_HIGH, high);
      csr_write(CSR_PEAK_LOW, low);
      csr_write(CSR_ZERO_WINDOW_LOW, wlo);
      csr_write(CSR_ZERO_WINDOW_HIGH, whi);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic offer(sample_set_type s);
      sample_sets.push_back(s);
      items_queued++;
   endtask

   task automatic settle();
      while (items_accepted != items_queued) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SW-1:0] draw_sample(draw_kind_type kind);
      int v;
      case (kind)
         DRAW_ARM: begin
            if (thr_high < SAMPLE_MAX && (thr_low == 0 || $urandom_range(0, 1) == 1))
               return SW'($urandom_range(int'(thr_high) + 1, SAMPLE_MAX));
            if (thr_low > 0) return SW'($urandom_range(0, int'(thr_low) - 1));
            return SW'($urandom_range(0, SAMPLE_MAX));
         end
         DRAW_ZERO: begin
            if (win_low <= win_high) return SW'($urandom_range(int'(win_low), int'(win_high)));
            return SW'($urandom_range(0, SAMPLE_MAX));
         end
         DRAW_QUIET: begin
            v = 0;
            for (int t = 0; t < 8; t++) begin
               if (thr_low <= thr_high) v = $urandom_range(int'(thr_low), int'(thr_high));
               else v = $urandom_range(0, SAMPLE_MAX);
               if (v < int'(win_low) || v > int'(win_high)) return SW'(v);
            end
            return SW'(v);
         end
         default: return SW'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   // Arm and then finish each channel in a random order; drop out part way now and then.
   task automatic queue_round();
      int order[4];
      bit arrived[4];
      sample_set_type s;
      int c, tmp, pick;
      for (int j = 0; j < 4; j++) begin
         order[j] = j;
         arrived[j] = 1'b0;
      end
      for (int j = 3; j > 0; j--) begin
         pick = $urandom_range(0, j);
         tmp = order[j];
         order[j] = order[pick];
         order[pick] = tmp;
      end
      for (int k = 0; k < 4; k++) begin
         c = order[k];
         for (int j = 0; j < 4; j++)
            s[j] = (j == c) ? draw_sample(DRAW_ARM) :
                   arrived[j] ? draw_sample(DRAW_ANY) :
                   draw_sample(($urandom_range(0, 1) == 1) ? DRAW_ARM : DRAW_QUIET);
         offer(s);
         if ($urandom_range(0, 3) == 0) begin
            for (int j = 0; j < 4; j++)
               s[j] = arrived[j] ? draw_sample(DRAW_ANY) : draw_sample(DRAW_QUIET);
            offer(s);
         end
         for (int j = 0; j < 4; j++)
            s[j] = (j == c) ? draw_sample(DRAW_ZERO) :
                   arrived[j] ? draw_sample(DRAW_ANY) : draw_sample(DRAW_QUIET);
         if (k < 3 && $urandom_range(0, 99) < 15) s[order[k + 1]] = draw_sample(DRAW_ZERO);
         offer(s);
         arrived[c] = 1'b1;
         if ($urandom_range(0, 99) < 4) return;
      end
   endtask

   task automatic queue_noise(int count);
      sample_set_type s;
      for (int n = 0; n < count; n++) begin
         for (int j = 0; j < 4; j++) s[j] = draw_sample(DRAW_ANY);
         offer(s);
      end
   endtask

   // Compact round at reset thresholds: arm all, then finish a, then b, then c and d together.
   task automatic queue_order(int a, int b, int c, int d);
      sample_set_type s;
      for (int j = 0; j < 4; j++) s[j] = (j % 2 == 1) ? SW'(0) : SW'(SAMPLE_MAX);
      offer(s);
      s = {SW'(600), SW'(600), SW'(600), SW'(600)};
      s[a] = SW'(512);
      offer(s);
      s[a] = SW'(600);
      s[b] = SW'(511);
      offer(s);
      s[b] = SW'(600);
      s[c] = SW'(514);
      s[d] = SW'(513);
      offer(s);
   endtask

   task automatic run_phase(int high, int low, int wlo, int whi, int rounds, int noise);
      set_thresholds(high, low, wlo, whi);
      for (int r = 0; r < rounds; r++) begin
         queue_round();
         if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 2));
      end
      queue_noise(noise);
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_UNUSED, 0);
      @(posedge clock);
      csr_write_enable <= 1'b0;

      // threshold and window boundaries at reset values, two channels finishing together
      offer({SW'(299), SW'(300), SW'(700), SW'(701)});
      offer({SW'(516), SW'(0), SW'(1023), SW'(510)});
      offer({SW'(600), SW'(516), SW'(515), SW'(0)});
      offer({SW'(513), SW'(512), SW'(600), SW'(1)});
      queue_order(1, 2, 0, 3);
      queue_order(2, 3, 0, 1);
      queue_order(3, 0, 1, 2);
      queue_order(0, 2, 1, 3);
      queue_order(3, 1, 0, 2);
      settle();

      steady = 1'b1;
      run_phase(PEAK_HIGH_RESET, PEAK_LOW_RESET, ZERO_WINDOW_LOW_RESET,
                ZERO_WINDOW_HIGH_RESET, 8, 0);
      steady = 1'b0;
      run_phase(SAMPLE_MAX, 0, 0, SAMPLE_MAX, 3, 8);
      squeeze = 1'b1;
      run_phase(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0, 60);
      run_phase(700, 300, 600, 400, 4, 4);
      run_phase(0, 0, 1000, SAMPLE_MAX, 6, 6);
      for (int p = 0; p < 4; p++) begin : random_phase
         int wlo;
         wlo = $urandom_range(200, 800);
         run_phase($urandom_range(400, SAMPLE_MAX), $urandom_range(0, 600), wlo,
                   wlo + $urandom_range(0, 40), 8, 5);
      end

      if (mismatches == 0) begin
         $display("impulse_arrival_quadrant_detector_unit: match");
      end else begin
         $display("impulse_arrival_quadrant_detector_unit: mismatch");
      end
      $finish;
   end

endmodule
